### hw/rtl/top_k_min_heap_selector_core_macros.svh
// Assertion macros shared by the top-k min-heap selector RTL.
`ifndef TOP_K_MIN_HEAP_SELECTOR_CORE_MACROS_SVH
`define TOP_K_MIN_HEAP_SELECTOR_CORE_MACROS_SVH

`ifndef SYNTHESIS
// Concurrent check with an explicit clock and reset.
`define TKMH_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("top-k heap selector check failed");
// Concurrent check on the module's own clock and reset.
`define TKMH_ASSERT_CLK(lbl, prop) `TKMH_ASSERT(lbl, clock, reset, prop)
`else
`define TKMH_ASSERT(lbl, clk, rst, prop)
`define TKMH_ASSERT_CLK(lbl, prop)
`endif

`endif

### hw/rtl/tkmh_pkg.sv
// Constants and codes for the top-k min-heap selector.
`default_nettype none
package tkmh_pkg;

   // Heap capacity and derived widths.
   localparam int MAX_KEEP = 16;
   localparam int SLOT_W   = $clog2(MAX_KEEP + 1);
   localparam int ADDR_W   = (MAX_KEEP > 1) ? $clog2(MAX_KEEP) : 1;

   // Fixed field widths of the ports.
   localparam int DATA_W    = 32;
   localparam int FUNC_W    = 2;
   localparam int KEEP_W    = 5;
   localparam int FIELD_W   = 5;
   localparam int RSP_USED  = DATA_W + 2 * FIELD_W + 1;
   localparam int RSP_W     = ((RSP_USED + 7) / 8) * 8;
   localparam int RSP_PAD_W = RSP_W - RSP_USED;

   // Reset value of the keep count register.
   localparam logic [KEEP_W-1:0] KEEP_RESET = KEEP_W'(4);

   // Function codes carried in the request tuser.
   localparam logic [FUNC_W-1:0] FUNC_OFFER = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_DUMP  = 2'd2;

endpackage
`default_nettype wire

### hw/rtl/top_k_min_heap_selector_core.sv
// Top-k selector keeping the largest signed samples in a min-heap, with its sequencer.
//
// Keeps the k largest signed 32-bit samples seen on the request stream in a min-heap of
// up to 16 slots; k comes from the keep_count register (0 reads as 1, above 16 as 16), and
// a write of it empties the heap. The first k offers fill slots in arrival order, and for
// k > 1 the k-th triggers a bottom-up heap build; later offers replace the root only when
// strictly greater. An offer, a clear or an unused code returns one item with the root; a
// dump returns one item per stored slot in index order, tlast on the final one. One item
// is worked on at a time and req_tready is low while it is busy. Timing is set by the slot
// memory (one write port, two registered read ports) and the single sift-down comparator,
// which work each heap level in a read state and then a compare state. An offer while
// filling goes straight to the report; any other offer reads and checks the root first,
// and a replacing one then sifts down level by level until the sample settles. The offer
// that completes the fill first runs the k/2 build steps, each loading one parent and
// sifting it down. A stalled rsp side holds the sequencer only while a result waits in the
// output register; the last result of an item sitting there does not block acceptance of
// the next request.
`default_nettype none
`include "top_k_min_heap_selector_core_macros.svh"

module top_k_min_heap_selector_core
   import tkmh_pkg::*;
(
   input  wire  logic                clock,
   input  wire  logic                reset,
   // Request stream.
   input  wire  logic                req_tvalid,
   output logic                      req_tready,
   input  wire  logic [DATA_W-1:0]   req_tdata,   // [31:0] sample
   input  wire  logic [FUNC_W-1:0]   req_tuser,   // [1:0] func
   // Result stream.
   output logic                      rsp_tvalid,
   input  wire  logic                rsp_tready,
   output logic [RSP_W-1:0]          rsp_tdata,   // [31:0] entry, [36:32] slot,
                                                  // [41:37] filled, [42] full_res, rest zero
   output logic                      rsp_tlast,   // last result of this item
   // Keep count register write.
   input  wire  logic                csr_valid,
   output logic                      csr_ready,
   input  wire  logic [KEEP_W-1:0]   csr_data
);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_BUILD_RD,
      ST_BUILD_LD,
      ST_ROOT_RD,
      ST_ROOT_CHK,
      ST_SIFT_RD,
      ST_SIFT_CMP,
      ST_EMIT_RD,
      ST_EMIT
   } state_type;

   // Signed greater-than on two's complement words.
   function automatic logic sgt(input logic [DATA_W-1:0] a, input logic [DATA_W-1:0] b);
      return $signed(a) > $signed(b);
   endfunction

   state_type               state_ff, state_in;
   logic [SLOT_W-1:0]       fill_ff, fill_in;
   logic [KEEP_W-1:0]       keep_ff, keep_in;
   logic                    dump_ff, dump_in;
   logic                    build_ff, build_in;
   logic                    right_ff, right_in;
   logic [SLOT_W-1:0]       pos_ff, pos_in;
   logic [SLOT_W-1:0]       par_ff, par_in;
   logic [SLOT_W-1:0]       cnt_ff, cnt_in;
   logic [DATA_W-1:0]       val_ff, val_in;
   logic [DATA_W-1:0]       sample_ff, sample_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [RSP_W-1:0]        rsp_data_ff, rsp_data_in;
   logic                    rsp_last_ff, rsp_last_in;

   // Slot memory: slot s lives at address s-1.
   logic [DATA_W-1:0]       heap_ff [MAX_KEEP];
   logic [DATA_W-1:0]       rd0_ff, rd1_ff;
   logic                    wr_en, rd_en;
   logic [ADDR_W-1:0]       wr_addr, rd_addr0, rd_addr1;
   logic [DATA_W-1:0]       wr_data;

   logic [SLOT_W-1:0]       keep_eff;
   logic [SLOT_W:0]         keep_w;
   logic [SLOT_W:0]         child;
   logic                    out_free;
   logic                    req_fire, csr_fire;
   logic                    take_right;
   logic [DATA_W-1:0]       child_val;
   logic [SLOT_W-1:0]       child_idx;
   logic                    sift_done;
   logic                    emit_last;
   logic                    full_flag;
   logic [FIELD_W-1:0]      slot_field;

   // Effective keep count, clamped to 1..MAX_KEEP.
   always_comb begin
      if (keep_ff == '0) begin
         keep_eff = SLOT_W'(1);
      end else if (32'(keep_ff) > 32'(MAX_KEEP)) begin
         keep_eff = SLOT_W'(MAX_KEEP);
      end else begin
         keep_eff = SLOT_W'(keep_ff);
      end
   end

   assign keep_w     = {1'b0, keep_eff};
   assign child      = {pos_ff, 1'b0};
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign csr_ready  = (state_ff == ST_IDLE);
   assign req_tready = (state_ff == ST_IDLE) && !csr_valid;
   assign csr_fire   = csr_valid && csr_ready;
   assign req_fire   = req_tvalid && req_tready;

   // Choice of child: the left one unless it is strictly greater than the right one.
   assign take_right = right_ff && sgt(rd0_ff, rd1_ff);
   assign child_val  = take_right ? rd1_ff : rd0_ff;
   assign child_idx  = SLOT_W'(child) + SLOT_W'(take_right);

   // Result fields.
   assign full_flag  = (fill_ff != '0) && (fill_ff == keep_eff);
   assign emit_last  = !dump_ff || (fill_ff == '0) || (cnt_ff == fill_ff);
   assign slot_field = (fill_ff == '0) ? '0 : FIELD_W'(cnt_ff);

   // Sequencer next-state logic.
   always_comb begin
      state_in     = state_ff;
      fill_in      = fill_ff;
      keep_in      = keep_ff;
      dump_in      = dump_ff;
      build_in     = build_ff;
      right_in     = right_ff;
      pos_in       = pos_ff;
      par_in       = par_ff;
      cnt_in       = cnt_ff;
      val_in       = val_ff;
      sample_in    = sample_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      wr_en        = 1'b0;
      wr_addr      = ADDR_W'(pos_ff - 1'b1);
      wr_data      = val_ff;
      rd_en        = 1'b0;
      rd_addr0     = '0;
      rd_addr1     = '0;
      sift_done    = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (csr_fire) begin
               keep_in = csr_data;
               fill_in = '0;
            end else if (req_fire) begin
               cnt_in   = SLOT_W'(1);
               dump_in  = (req_tuser == FUNC_DUMP);
               build_in = 1'b0;
               state_in = ST_EMIT_RD;
               priority if (req_tuser == FUNC_OFFER) begin
                  if (fill_ff < keep_eff) begin
                     // Still filling: append the sample.
                     wr_en   = 1'b1;
                     wr_addr = ADDR_W'(fill_ff);
                     wr_data = req_tdata;
                     fill_in = SLOT_W'(fill_ff + 1'b1);
                     if ((SLOT_W'(fill_ff + 1'b1) == keep_eff) && (keep_eff > SLOT_W'(1))) begin
                        build_in = 1'b1;
                        par_in   = keep_eff >> 1;
                        state_in = ST_BUILD_RD;
                     end
                  end else begin
                     sample_in = req_tdata;
                     state_in  = ST_ROOT_RD;
                  end
               end else if (req_tuser == FUNC_CLEAR) begin
                  fill_in = '0;
               end else begin
                  // Dump and the unused code only report.
               end
            end
         end
         ST_BUILD_RD: begin
            rd_en    = 1'b1;
            rd_addr0 = ADDR_W'(par_ff - 1'b1);
            state_in = ST_BUILD_LD;
         end
         ST_BUILD_LD: begin
            val_in   = rd0_ff;
            pos_in   = par_ff;
            state_in = ST_SIFT_RD;
         end
         ST_ROOT_RD: begin
            rd_en    = 1'b1;
            rd_addr0 = '0;
            state_in = ST_ROOT_CHK;
         end
         ST_ROOT_CHK: begin
            // Replace the root only with a strictly greater sample.
            if (sgt(sample_ff, rd0_ff)) begin
               val_in   = sample_ff;
               pos_in   = SLOT_W'(1);
               state_in = ST_SIFT_RD;
            end else begin
               state_in = ST_EMIT_RD;
            end
         end
         ST_SIFT_RD: begin
            if (child > keep_w) begin
               // No children: the moving value settles here.
               wr_en     = 1'b1;
               sift_done = 1'b1;
            end else begin
               rd_en    = 1'b1;
               rd_addr0 = ADDR_W'(child - 1'b1);
               rd_addr1 = ADDR_W'(child);
               right_in = (child < keep_w);
               state_in = ST_SIFT_CMP;
            end
         end
         ST_SIFT_CMP: begin
            wr_en = 1'b1;
            if (sgt(val_ff, child_val)) begin
               // Pull the smaller child up into the hole and go one level down.
               wr_data  = child_val;
               pos_in   = child_idx;
               state_in = ST_SIFT_RD;
            end else begin
               sift_done = 1'b1;
            end
         end
         ST_EMIT_RD: begin
            rd_en    = 1'b1;
            rd_addr0 = ADDR_W'(cnt_ff - 1'b1);
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_last_in  = emit_last;
               rsp_data_in  = {{RSP_PAD_W{1'b0}}, full_flag, FIELD_W'(fill_ff), slot_field,
                               (fill_ff == '0) ? DATA_W'(0) : rd0_ff};
               if (emit_last) begin
                  state_in = ST_IDLE;
               end else begin
                  cnt_in   = SLOT_W'(cnt_ff + 1'b1);
                  state_in = ST_EMIT_RD;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // End of one sift-down: next build step, or report.
      if (sift_done) begin
         if (build_ff && (par_ff > SLOT_W'(1))) begin
            par_in   = SLOT_W'(par_ff - 1'b1);
            state_in = ST_BUILD_RD;
         end else begin
            build_in = 1'b0;
            cnt_in   = SLOT_W'(1);
            state_in = ST_EMIT_RD;
         end
      end
   end

   // State and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fill_ff      <= '0;
         keep_ff      <= KEEP_RESET;
         dump_ff      <= 1'b0;
         build_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         keep_ff      <= keep_in;
         dump_ff      <= dump_in;
         build_ff     <= build_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      right_ff    <= right_in;
      pos_ff      <= pos_in;
      par_ff      <= par_in;
      cnt_ff      <= cnt_in;
      val_ff      <= val_in;
      sample_ff   <= sample_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   // Slot memory write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         heap_ff[wr_addr] <= wr_data;
      end
   end

   // Slot memory read ports, registered.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd0_ff <= heap_ff[rd_addr0];
         rd1_ff <= heap_ff[rd_addr1];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   // The fill level never runs past the effective keep count.
   `TKMH_ASSERT_CLK(a_fill_in_range, fill_ff <= keep_eff)
   // A child compare only happens for a child that lies inside the heap.
   `TKMH_ASSERT_CLK(a_child_in_heap, (state_ff == ST_SIFT_CMP) |-> (child <= keep_w))
   // A keep count write leaves the heap empty.
   `TKMH_ASSERT_CLK(a_csr_clears, csr_fire |=> (fill_ff == '0))
   // A dump never reports a slot beyond the fill level.
   `TKMH_ASSERT_CLK(a_dump_slot_range,
      (state_ff == ST_EMIT) |-> ((cnt_ff <= fill_ff) || (fill_ff == '0)))

endmodule
`default_nettype wire
